### rtl/fwsp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsp_pkg
// Shared operation codes, status codes and the result record of the queue.
// ----------------------------------------------------------------------------
package fwsp_pkg;

  localparam int VALUE_W = 32;
  localparam int COUNT_W = 5;

  // operation codes carried on in_mode
  localparam logic [2:0] MODE_PUSH     = 3'd0;
  localparam logic [2:0] MODE_POP      = 3'd1;
  localparam logic [2:0] MODE_PEEK     = 3'd2;
  localparam logic [2:0] MODE_CONTAINS = 3'd3;
  localparam logic [2:0] MODE_COUNT    = 3'd4;
  localparam logic [2:0] MODE_PURGE    = 3'd5;
  localparam logic [2:0] MODE_CLEAR    = 3'd6;

  // status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic signed [VALUE_W-1:0] read_value;
    logic                      found;
    logic [COUNT_W-1:0]        match_count;
    logic [COUNT_W-1:0]        occupancy;
    logic [1:0]                status;
  } res_t;

endpackage

### rtl/fwsp_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsp_mem
// Entry store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module fwsp_mem #(
  parameter int QUEUE_DEPTH = 16,
  parameter int IW          = 4
) (
  input  logic                           clk,
  input  logic                           wr_en,
  input  logic [IW-1:0]                  wr_addr,
  input  logic [fwsp_pkg::VALUE_W-1:0]   wr_data,
  input  logic                           rd_en,
  input  logic [IW-1:0]                  rd_addr,
  output logic [fwsp_pkg::VALUE_W-1:0]   rd_data
);

  logic [fwsp_pkg::VALUE_W-1:0] mem [QUEUE_DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/fwsp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fwsp_ctrl
// Queue sequencer: pointers, operation decode and the search/purge walk.
// ----------------------------------------------------------------------------
module fwsp_ctrl #(
  parameter int QUEUE_DEPTH = 16,
  parameter int IW          = 4,
  parameter int CW          = 5
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          in_mode,
  input  logic signed [fwsp_pkg::VALUE_W-1:0] in_value,
  output logic                                res_vld,
  output fwsp_pkg::res_t                      res,
  input  logic                                res_take,
  output logic                                wr_en,
  output logic [IW-1:0]                       wr_addr,
  output logic [fwsp_pkg::VALUE_W-1:0]        wr_data,
  output logic                                rd_en,
  output logic [IW-1:0]                       rd_addr,
  input  logic [fwsp_pkg::VALUE_W-1:0]        rd_data
);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_WALK   = 3'b010,
    S_FINISH = 3'b100
  } state_t;

  state_t                        state_r, state_nxt;
  logic [IW-1:0]                 front_r, front_nxt;
  logic [CW-1:0]                 count_r, count_nxt;
  logic [2:0]                    mode_r, mode_nxt;
  logic [fwsp_pkg::VALUE_W-1:0]  value_r, value_nxt;
  logic [1:0]                    st_r, st_nxt;
  logic [CW-1:0]                 rd_off_r, rd_off_nxt;
  logic [CW-1:0]                 wr_off_r, wr_off_nxt;
  logic [CW-1:0]                 match_r, match_nxt;
  logic                          found_r, found_nxt;
  logic                          hit;
  logic [CW+fwsp_pkg::COUNT_W-1:0] match_ext, count_ext;

  // front + offset modulo depth; both operands stay below the depth
  function automatic logic [IW-1:0] wrap(input logic [IW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [CW:0] s;
    s = (CW+1)'(base) + (CW+1)'(off);
    if (s >= (CW+1)'(QUEUE_DEPTH)) s = s - (CW+1)'(QUEUE_DEPTH);
    return s[IW-1:0];
  endfunction

  assign hit      = (rd_data == value_r);
  assign in_stall = (state_r != S_IDLE);

  always_comb begin
    state_nxt  = state_r;
    front_nxt  = front_r;
    count_nxt  = count_r;
    mode_nxt   = mode_r;
    value_nxt  = value_r;
    st_nxt     = st_r;
    rd_off_nxt = rd_off_r;
    wr_off_nxt = wr_off_r;
    match_nxt  = match_r;
    found_nxt  = found_r;
    wr_en      = 1'b0;
    wr_addr    = '0;
    wr_data    = '0;
    rd_en      = 1'b0;
    rd_addr    = '0;
    res_vld    = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          mode_nxt   = in_mode;
          value_nxt  = in_value;
          st_nxt     = fwsp_pkg::ST_OK;
          rd_off_nxt = '0;
          wr_off_nxt = '0;
          match_nxt  = '0;
          found_nxt  = 1'b0;
          state_nxt  = S_FINISH;
          unique case (in_mode)
            fwsp_pkg::MODE_PUSH: begin
              if (count_r == CW'(QUEUE_DEPTH)) begin
                st_nxt = fwsp_pkg::ST_FULL;
              end else begin
                wr_en     = 1'b1;
                wr_addr   = wrap(front_r, count_r);
                wr_data   = in_value;
                count_nxt = count_r + CW'(1);
              end
            end
            fwsp_pkg::MODE_POP, fwsp_pkg::MODE_PEEK: begin
              if (count_r == '0) begin
                st_nxt = fwsp_pkg::ST_EMPTY;
              end else begin
                rd_en   = 1'b1;
                rd_addr = front_r;
                if (in_mode == fwsp_pkg::MODE_POP) begin
                  front_nxt = wrap(front_r, CW'(1));
                  count_nxt = count_r - CW'(1);
                end
              end
            end
            fwsp_pkg::MODE_CONTAINS, fwsp_pkg::MODE_COUNT, fwsp_pkg::MODE_PURGE: begin
              if (count_r != '0) begin
                rd_en      = 1'b1;
                rd_addr    = front_r;
                rd_off_nxt = CW'(1);
                state_nxt  = S_WALK;
              end
            end
            fwsp_pkg::MODE_CLEAR: begin
              count_nxt = '0;
              front_nxt = '0;
            end
            default: ;
          endcase
        end
      end
      S_WALK: begin
        // entry read last cycle is checked now; survivors of a purge are
        // packed toward the front, always behind the read offset
        if (hit) begin
          match_nxt = match_r + CW'(1);
          found_nxt = 1'b1;
        end else if (mode_r == fwsp_pkg::MODE_PURGE) begin
          wr_en      = 1'b1;
          wr_addr    = wrap(front_r, wr_off_r);
          wr_data    = rd_data;
          wr_off_nxt = wr_off_r + CW'(1);
        end
        if (rd_off_r != count_r) begin
          rd_en      = 1'b1;
          rd_addr    = wrap(front_r, rd_off_r);
          rd_off_nxt = rd_off_r + CW'(1);
        end else begin
          state_nxt = S_FINISH;
          if (mode_r == fwsp_pkg::MODE_PURGE) begin
            count_nxt = wr_off_nxt;
          end
        end
      end
      S_FINISH: begin
        res_vld = 1'b1;
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign match_ext = {{fwsp_pkg::COUNT_W{1'b0}}, match_r};
  assign count_ext = {{fwsp_pkg::COUNT_W{1'b0}}, count_r};

  always_comb begin
    res            = '0;
    res.status     = st_r;
    res.occupancy  = count_ext[fwsp_pkg::COUNT_W-1:0];
    if ((mode_r == fwsp_pkg::MODE_POP || mode_r == fwsp_pkg::MODE_PEEK) &&
        st_r == fwsp_pkg::ST_OK) begin
      res.read_value = rd_data;
    end
    if (mode_r == fwsp_pkg::MODE_CONTAINS) begin
      res.found = found_r;
    end
    if (mode_r == fwsp_pkg::MODE_COUNT || mode_r == fwsp_pkg::MODE_PURGE) begin
      res.match_count = match_ext[fwsp_pkg::COUNT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      front_r <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      front_r <= front_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mode_r   <= mode_nxt;
    value_r  <= value_nxt;
    st_r     <= st_nxt;
    rd_off_r <= rd_off_nxt;
    wr_off_r <= wr_off_nxt;
    match_r  <= match_nxt;
    found_r  <= found_nxt;
  end

  // occupancy never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(QUEUE_DEPTH))
    else $error("occupancy above depth");

  // purge writer never overtakes the reader
  a_wr_behind_rd: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK) |-> (wr_off_r < rd_off_r))
    else $error("purge write offset ahead of read offset");

  // no same-entry read and write in one cycle
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    (wr_en && rd_en) |-> (wr_addr != rd_addr))
    else $error("read and write hit the same entry");

  // a taken result returns the sequencer to idle
  a_finish_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (res_vld && res_take) |=> (state_r == S_IDLE))
    else $error("sequencer did not return to idle");

endmodule

### rtl/fifo_with_search_and_purge.sv
`timescale 1ns / 1ps
// Result path: the request is registered in the sequencer state, then the
// result loads into the output register. A stalled output holds the result
// in S_FINISH, and in_stall keeps new items out until the result is taken.
// Contains, count and purge walk the store one entry per cycle through its
// single read port before S_FINISH.
// Reset (rst_n low, synchronous): queue empty, front at entry 0, no result.
// ----------------------------------------------------------------------------
// fifo_with_search_and_purge
// Bounded FIFO of signed 32-bit values with membership search, match count,
// order-preserving purge and clear. The entry store is not cleared; only
// occupied entries are ever read.
// ----------------------------------------------------------------------------
module fifo_with_search_and_purge #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [2:0]                          in_mode,
  input  logic signed [fwsp_pkg::VALUE_W-1:0] in_value,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [fwsp_pkg::VALUE_W-1:0] out_read_value,
  output logic                                out_found,
  output logic [fwsp_pkg::COUNT_W-1:0]        out_match_count,
  output logic [fwsp_pkg::COUNT_W-1:0]        out_occupancy,
  output logic [1:0]                          out_status
);

  // store index width and a count width that can hold the depth itself
  localparam int IW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic                          res_vld;
  logic                          res_take;
  fwsp_pkg::res_t                res;
  logic                          wr_en;
  logic [IW-1:0]                 wr_addr;
  logic [fwsp_pkg::VALUE_W-1:0]  wr_data;
  logic                          rd_en;
  logic [IW-1:0]                 rd_addr;
  logic [fwsp_pkg::VALUE_W-1:0]  rd_data;

  // output register: holds the last result until its transfer
  logic                          out_valid_r, out_valid_nxt;
  fwsp_pkg::res_t                out_r, out_nxt;

  fwsp_ctrl #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IW          (IW),
    .CW          (CW)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_mode  (in_mode),
    .in_value (in_value),
    .res_vld  (res_vld),
    .res      (res),
    .res_take (res_take),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data)
  );

  fwsp_mem #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IW          (IW)
  ) u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // a new result may load when the register is empty or is being drained
  assign res_take = !out_valid_r || !out_stall;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (res_vld && res_take) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_read_value  = out_r.read_value;
  assign out_found       = out_r.found;
  assign out_match_count = out_r.match_count;
  assign out_occupancy   = out_r.occupancy;
  assign out_status      = out_r.status;

endmodule
